// File: rtl/core/mde_pkg.sv
// Shared types, constants and round functions of the MD5 digest engine.
package mde_pkg;

    // Input word: one optional message byte and the end-of-message mark
    typedef struct packed {
        logic       has_byte;
        logic [7:0] data_byte;
        logic       is_last;
    } t_in_word;

    // Output word: eight digest bytes, lowest byte in bits 7:0
    typedef struct packed {
        logic [63:0] digest_part;
        logic        part_last;
    } t_out_word;

    // Head of the queue between front and back
    typedef struct packed {
        logic     valid;
        t_in_word word;
    } t_q_head;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int BLOCK_WORDS = 16;
    localparam int LANE_COUNT  = 4;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [7:0] PAD_ZERO   = 8'h00;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] LAST_SLOT  = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amount of a round: four amounts per group of sixteen rounds
    function automatic logic [4:0] rot_amt(input logic [5:0] rnd);
        logic [4:0] amt;
        case (rnd[5:4])
            2'd0: begin
                case (rnd[1:0])
                    2'd0:    amt = 5'd7;
                    2'd1:    amt = 5'd12;
                    2'd2:    amt = 5'd17;
                    default: amt = 5'd22;
                endcase
            end
            2'd1: begin
                case (rnd[1:0])
                    2'd0:    amt = 5'd5;
                    2'd1:    amt = 5'd9;
                    2'd2:    amt = 5'd14;
                    default: amt = 5'd20;
                endcase
            end
            2'd2: begin
                case (rnd[1:0])
                    2'd0:    amt = 5'd4;
                    2'd1:    amt = 5'd11;
                    2'd2:    amt = 5'd16;
                    default: amt = 5'd23;
                endcase
            end
            default: begin
                case (rnd[1:0])
                    2'd0:    amt = 5'd6;
                    2'd1:    amt = 5'd10;
                    2'd2:    amt = 5'd15;
                    default: amt = 5'd21;
                endcase
            end
        endcase
        return amt;
    endfunction

    // Message word index of a round, taken modulo sixteen
    function automatic logic [3:0] word_sel(input logic [5:0] rnd);
        logic [3:0] low;
        logic [3:0] sel;
        low = rnd[3:0];
        case (rnd[5:4])
            2'd0:    sel = low;
            2'd1:    sel = 4'(low * 4'd5 + 4'd1);
            2'd2:    sel = 4'(low * 4'd3 + 4'd5);
            default: sel = 4'(low * 4'd7);
        endcase
        return sel;
    endfunction

    // Rotate a 32-bit value left
    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] dbl;
        dbl = {x, x} << n;
        return dbl[63:32];
    endfunction

endpackage

// File: rtl/core/mde_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, register one read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/mde_front.sv
// Front end: accepts input words, drops idle words, queues the rest.
module mde_front import mde_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_word i_in_word,
    input  logic     i_pop,
    output t_q_head  o_head
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    t_in_word      r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    // Keep only words that carry a byte or end a message
    assign o_in_stall = (r_count == FULL_CNT);
    assign push = i_in_valid && !o_in_stall && (i_in_word.has_byte || i_in_word.is_last);
    assign pop  = i_pop && (r_count != '0);

    assign n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;

    assign o_head.valid = (r_count != '0);
    assign o_head.word  = r_slot[r_rd_ptr];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Hold queued words
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_in_word;
        end
    end

endmodule

// File: rtl/core/mde_back.sv
// Back end: block store, padding sequencer, MD5 round unit and output register.
module mde_back import mde_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_head   i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_LOAD, S_ROUND, S_ADD, S_OUT0, S_OUT1
    } t_state;

    typedef enum logic [1:0] {
        P_MARK, P_ZERO, P_LEN
    } t_pad;

    t_state      r_state;
    t_pad        r_pad;
    logic        r_fin;
    logic        r_len_done;
    logic [5:0]  r_fill;
    logic [60:0] r_total;
    logic [5:0]  r_round;
    logic [31:0] r_ha, r_hb, r_hc, r_hd;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic        r_out_valid;
    t_out_word   r_out_word;

    logic        wr_en;
    logic [7:0]  wr_byte;
    logic [3:0]  rd_addr;
    logic [31:0] w_word;
    logic [63:0] bit_len;
    logic [7:0]  len_byte;
    logic [31:0] f_val;
    logic [31:0] sum;
    logic [31:0] n_b;
    logic        out_free;

    // Block store: one byte lane per RAM, word index as address
    for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
        mde_ram #(
            .WIDTH(8),
            .DEPTH(BLOCK_WORDS)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (wr_en && (r_fill[1:0] == 2'(g))),
            .i_waddr(r_fill[5:2]),
            .i_wdata(wr_byte),
            .i_raddr(rd_addr),
            .o_rdata(w_word[8*g +: 8])
        );
    end

    assign bit_len  = {r_total, 3'b000};
    assign len_byte = bit_len[{r_fill[2:0], 3'b000} +: 8];
    assign o_pop    = (r_state == S_IDLE) && i_head.valid;
    assign rd_addr  = (r_state == S_LOAD) ? word_sel(6'd0) : word_sel(r_round + 6'd1);
    assign out_free = !r_out_valid || !i_out_stall;

    // Select the byte written into the block
    always_comb begin
        wr_en   = 1'b0;
        wr_byte = i_head.word.data_byte;
        case (r_state)
            S_IDLE: begin
                wr_en = i_head.valid && i_head.word.has_byte;
            end
            S_PAD: begin
                wr_en = 1'b1;
                case (r_pad)
                    P_MARK:  wr_byte = PAD_MARK;
                    P_ZERO:  wr_byte = (r_fill == LEN_OFFSET) ? len_byte : PAD_ZERO;
                    default: wr_byte = len_byte;
                endcase
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // One MD5 round on the working words
    always_comb begin
        case (r_round[5:4])
            2'd0:    f_val = (r_b & r_c) | (~r_b & r_d);
            2'd1:    f_val = (r_d & r_b) | (~r_d & r_c);
            2'd2:    f_val = r_b ^ r_c ^ r_d;
            default: f_val = r_c ^ (r_b | ~r_d);
        endcase
        sum = r_a + f_val + ROUND_K[r_round] + w_word;
        n_b = r_b + rotl(sum, rot_amt(r_round));
    end

    // Sequence absorb, pad, compress and emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pad       <= P_MARK;
            r_fin       <= 1'b0;
            r_len_done  <= 1'b0;
            r_fill      <= '0;
            r_total     <= '0;
            r_round     <= '0;
            r_ha        <= IV_A;
            r_hb        <= IV_B;
            r_hc        <= IV_C;
            r_hd        <= IV_D;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the output word once taken; the digest states reload it themselves
            if (r_out_valid && !i_out_stall && !(r_state inside {S_OUT0, S_OUT1})) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_fin      <= i_head.word.is_last;
                        r_pad      <= P_MARK;
                        r_len_done <= 1'b0;
                        if (i_head.word.has_byte) begin
                            r_total <= r_total + 61'd1;
                            r_fill  <= r_fill + 6'd1;
                            if (r_fill == LAST_SLOT) begin
                                r_state <= S_LOAD;
                            end else if (i_head.word.is_last) begin
                                r_state <= S_PAD;
                            end
                        end else if (i_head.word.is_last) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_fill <= r_fill + 6'd1;
                    case (r_pad)
                        P_MARK: r_pad <= P_ZERO;
                        P_ZERO: begin
                            if (r_fill == LEN_OFFSET) begin
                                r_pad <= P_LEN;
                            end
                        end
                        default: r_pad <= P_LEN;
                    endcase
                    if (r_fill == LAST_SLOT) begin
                        r_len_done <= (r_pad == P_LEN);
                        r_state    <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_a     <= r_ha;
                    r_b     <= r_hb;
                    r_c     <= r_hc;
                    r_d     <= r_hd;
                    r_round <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_a     <= r_d;
                    r_d     <= r_c;
                    r_c     <= r_b;
                    r_b     <= n_b;
                    r_round <= r_round + 6'd1;
                    if (r_round == LAST_ROUND) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_ha <= r_ha + r_a;
                    r_hb <= r_hb + r_b;
                    r_hc <= r_hc + r_c;
                    r_hd <= r_hd + r_d;
                    if (!r_fin) begin
                        r_state <= S_IDLE;
                    end else if (r_len_done) begin
                        r_state <= S_OUT0;
                    end else begin
                        r_state <= S_PAD;
                    end
                end
                S_OUT0: begin
                    if (out_free) begin
                        r_out_valid            <= 1'b1;
                        r_out_word.digest_part <= {r_hb, r_ha};
                        r_out_word.part_last   <= 1'b0;
                        r_state                <= S_OUT1;
                    end
                end
                S_OUT1: begin
                    if (out_free) begin
                        r_out_valid            <= 1'b1;
                        r_out_word.digest_part <= {r_hd, r_hc};
                        r_out_word.part_last   <= 1'b1;
                        r_ha                   <= IV_A;
                        r_hb                   <= IV_B;
                        r_hc                   <= IV_C;
                        r_hd                   <= IV_D;
                        r_total                <= '0;
                        r_fill                 <= '0;
                        r_fin                  <= 1'b0;
                        r_len_done             <= 1'b0;
                        r_state                <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// File: rtl/core/md5_digest_engine.sv
// Top level of the MD5 digest engine: front queue and back compression unit.
//
// Input channel: i_in_valid / o_in_stall carry one word per accepted edge,
// holding an optional message byte (has_byte), the byte, and an end mark
// (is_last). Words with neither a byte nor an end mark are dropped.
// Output channel: o_out_valid / i_out_stall carry the digest as two words,
// digest bytes 0..7 first (part_last = 0), then bytes 8..15 (part_last = 1).
// Throughput: the back end takes one message byte per cycle, but no bytes
// while it loads, runs the 64 rounds and adds the chaining words of each
// 64-byte block; the single round unit and the one write port of the block
// store set this pace. Finishing a message writes the padding bytes (9 to
// 72 bytes) and compresses each padded block, then emits the digest words.
// The front queue holds QUEUE_DEPTH words, so the sender runs ahead of the
// back end by that many words; o_in_stall rises only when the queue is full.
// A stalled output word holds; the back end waits for the output register
// to free before it loads the next digest word.
// Reset (synchronous, active low) empties the queue, clears the output
// register, the byte count and the block fill, and loads the initial
// chaining words. Each digest ends with the count, fill and chaining words reset.
module md5_digest_engine import mde_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_q_head head;
    logic    pop;

    mde_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_word (i_in_word),
        .i_pop     (pop),
        .o_head    (head)
    );

    mde_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

endmodule

// File: rtl/core/mde_checker.sv
// Port-level checks of the MD5 digest engine, bound to the top level.
module mde_checker import mde_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    // Clear the output after reset
    a_out_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Follow the first digest word with the second at once
    a_second_part: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_word.part_last
        |=> o_out_valid && o_out_word.part_last)
        else $error("second digest word not presented after the first");

    // Leave a gap after the second digest word
    a_gap_after_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out_word.part_last |=> !o_out_valid)
        else $error("output word right after a finished digest");

endmodule

bind md5_digest_engine mde_checker u_mde_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_word (o_out_word)
);

// File: tb/md5_digest_engine_test.sv
// Testbench of the MD5 digest engine: byte stream in, checked digest words out.
`timescale 1ns / 1ps

module md5_digest_engine_test;
    import mde_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned TARGET_BYTES  = 1250;
    localparam int unsigned TAIL_CYCLES   = 300;
    localparam int unsigned LONG_HOLD     = 1500;
    localparam int unsigned HOLD_AT_WORD  = 14;
    localparam int unsigned REPORT_LIMIT  = 10;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  FIRST_PAD    = 8'h80;
    localparam logic [7:0]  ZERO_PAD     = 8'h00;
    localparam int unsigned LENGTH_SLOT  = 56;
    localparam int unsigned BLOCK_BYTES  = 64;

    // Sine-derived additive constants, one per round
    localparam logic [31:0] ADD_CONST [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Left-rotate amounts: row per group of sixteen rounds, column by round mod 4
    localparam int unsigned SHIFT_TAB [4][4] = '{
        '{7, 12, 17, 22}, '{5, 9, 14, 20}, '{4, 11, 16, 23}, '{6, 10, 15, 21}
    };

    // Message lengths around the padding and block edges
    localparam int unsigned PAD_BOUNDARY_LENS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

    typedef struct {
        t_in_word word;
        bit       drain;
    } t_feed_entry;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    t_feed_entry byte_feed[$];
    t_out_word   digest_expect[$];

    // Predictor state: chaining words, byte count and partial block
    logic [31:0] chain [4];
    logic [60:0] msg_bytes;
    logic [7:0]  blk [64];
    int unsigned blk_fill;

    int unsigned items_queued = 0;
    int unsigned mismatches   = 0;
    int unsigned words_seen   = 0;
    int unsigned cycles       = 0;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    int unsigned hold_left    = 0;
    bit          hold_on      = 1'b0;
    bit          hold_done    = 1'b0;
    bit          tx_burst     = 1'b0;
    bit          rx_burst     = 1'b0;

    md5_digest_engine dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic md5_restart();
        chain[0]  = INIT_A;
        chain[1]  = INIT_B;
        chain[2]  = INIT_C;
        chain[3]  = INIT_D;
        msg_bytes = '0;
        blk_fill  = 0;
    endtask

    // Run the 64 rounds over the full block and fold into the chaining words
    task automatic md5_compress();
        logic [31:0] m [16];
        logic [31:0] a, b, c, d, f, t;
        int unsigned g;
        for (int i = 0; i < 16; i++) begin
            m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
        end
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (int unsigned r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1: begin
                    f = (d & b) | (~d & c);
                    g = (5 * r + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            t = d;
            d = c;
            c = b;
            b = b + rol32(a + f + ADD_CONST[r] + m[g], SHIFT_TAB[r / 16][r % 4]);
            a = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
    endtask

    task automatic md5_take(input logic [7:0] v);
        blk[blk_fill] = v;
        blk_fill++;
        if (blk_fill == BLOCK_BYTES) begin
            md5_compress();
            blk_fill = 0;
        end
    endtask

    // Advance the predictor by one accepted word; queue the digest on the end mark
    task automatic md5_predict(input t_in_word w);
        logic [63:0] bit_len;
        t_out_word   part;
        if (w.has_byte) begin
            msg_bytes++;
            md5_take(w.data_byte);
        end
        if (w.is_last) begin
            bit_len = {msg_bytes, 3'b000};
            md5_take(FIRST_PAD);
            while (blk_fill != LENGTH_SLOT) md5_take(ZERO_PAD);
            for (int i = 0; i < 8; i++) md5_take(bit_len[8*i +: 8]);
            part.digest_part = {chain[1], chain[0]};
            part.part_last   = 1'b0;
            digest_expect    = {digest_expect, part};
            part.digest_part = {chain[3], chain[2]};
            part.part_last   = 1'b1;
            digest_expect    = {digest_expect, part};
            md5_restart();
        end
    endtask

    task automatic queue_word(input bit has, input logic [7:0] data, input bit last,
                              input bit drain);
        t_feed_entry e;
        e.word.has_byte  = has;
        e.word.data_byte = data;
        e.word.is_last   = last;
        e.drain          = drain;
        byte_feed        = {byte_feed, e};
        if (has || last) items_queued++;
    endtask

    // One message of random bytes, with stray idle words and a random kind of end
    task automatic queue_message(input int unsigned len, input bit drain);
        bit end_on_byte;
        bit first;
        end_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
        first       = drain;
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                queue_word(1'b0, 8'($urandom_range(0, 255)), 1'b0, first);
                first = 1'b0;
            end
            queue_word(1'b1, 8'($urandom_range(0, 255)), end_on_byte && (i == len - 1), first);
            first = 1'b0;
        end
        if (!end_on_byte) queue_word(1'b0, 8'($urandom_range(0, 255)), 1'b1, first);
    endtask

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("digest word %0d: %s expected %h, got %h", words_seen, field, want, got);
        end
    endtask

    // Driver: present the next pending word, hold it while stalled
    always @(posedge clk) begin
        t_feed_entry nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                md5_predict(in_word);
                if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
                gap_left = tx_burst ? 0 : $urandom_range(0, 3);
            end
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (byte_feed.size() != 0 &&
                             !(byte_feed[0].drain && digest_expect.size() != 0)) begin
                    nxt = byte_feed.pop_front();
                    in_valid <= 1'b1;
                    in_word  <= nxt.word;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off: start once after HOLD_AT_WORD digest words, count it down here
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_on <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            hold_on <= 1'b1;
        end else if (!hold_done && words_seen >= HOLD_AT_WORD) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
            hold_on <= 1'b1;
        end else begin
            hold_on <= 1'b0;
        end
    end

    // Monitor: check each accepted digest word, then draw the next stall
    always @(posedge clk) begin
        t_out_word want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                words_seen++;
                if (digest_expect.size() == 0) begin
                    note_mismatch("unexpected word", '0, out_word.digest_part);
                end else begin
                    want = digest_expect.pop_front();
                    if (out_word.digest_part !== want.digest_part) begin
                        note_mismatch("digest_part", want.digest_part, out_word.digest_part);
                    end
                    if (out_word.part_last !== want.part_last) begin
                        note_mismatch("part_last", 64'(want.part_last), 64'(out_word.part_last));
                    end
                end
                if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
                stall_left = rx_burst ? 0 : $urandom_range(0, 3);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= hold_on;
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int unsigned msg_idx;
        int unsigned len;
        md5_restart();

        // Empty message: end mark with no byte, the ignored data byte all ones
        queue_word(1'b0, 8'hff, 1'b1, 1'b0);
        // Idle word, then a single zero byte carrying the end mark
        queue_word(1'b0, 8'h5a, 1'b0, 1'b0);
        queue_word(1'b1, 8'h00, 1'b1, 1'b0);
        // Three bytes, finished by a bare end mark
        queue_word(1'b1, 8'h61, 1'b0, 1'b0);
        queue_word(1'b1, 8'h62, 1'b0, 1'b0);
        queue_word(1'b1, 8'h63, 1'b0, 1'b0);
        queue_word(1'b0, 8'h00, 1'b1, 1'b0);
        // Single all-ones byte with the end mark
        queue_word(1'b1, 8'hff, 1'b1, 1'b0);
        // Idle words inside a message
        queue_word(1'b1, 8'h80, 1'b0, 1'b0);
        queue_word(1'b0, 8'h00, 1'b0, 1'b0);
        queue_word(1'b1, 8'h7f, 1'b0, 1'b0);
        queue_word(1'b0, 8'haa, 1'b0, 1'b0);
        queue_word(1'b1, 8'h01, 1'b1, 1'b0);

        // Random messages, short ones mostly, plus lengths at the padding edges
        msg_idx = 0;
        while (items_queued < TARGET_BYTES) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: len = $urandom_range(0, 12);
                5, 6, 7:       len = PAD_BOUNDARY_LENS[$urandom_range(0, 7)];
                default:       len = $urandom_range(0, 140);
            endcase
            queue_message(len, (msg_idx == 0) || (msg_idx % 8 == 5));
            msg_idx++;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        do begin
            @(negedge clk);
        end while (byte_feed.size() != 0 || in_valid || digest_expect.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && digest_expect.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/mde_pkg.sv
rtl/core/mde_ram.sv
rtl/core/mde_front.sv
rtl/core/mde_back.sv
rtl/core/md5_digest_engine.sv
rtl/core/mde_checker.sv
tb/md5_digest_engine_test.sv
